[hw/rtl/bbpa_pkg.sv]
// shared types and constants of the bitmap block pool allocator
// depends on nothing; used by the interfaces, the divider, the top level and the checker
`default_nettype none

package bbpa_pkg;

    // field widths of the request and result beats
    localparam int ADDR_FIELD_W  = 32;
    localparam int SIZE_W        = 16;
    localparam int COUNT_FIELD_W = 7;

    // configuration port
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam logic [1:0] REG_BASE_ADDRESS  = 2'd0;
    localparam logic [1:0] REG_BLOCK_BYTES   = 2'd1;
    localparam logic [1:0] REG_ACTIVE_BLOCKS = 2'd2;

    // reset values of the registers
    localparam logic [ADDR_FIELD_W-1:0]  RST_BASE_ADDRESS  = 32'd0;
    localparam logic [SIZE_W-1:0]        RST_BLOCK_BYTES   = 16'd16;
    localparam logic [COUNT_FIELD_W-1:0] RST_ACTIVE_BLOCKS = 7'd64;

    // use map row layout
    localparam int ROW_BITS  = 32;
    localparam int ROW_IDX_W = 5;

    // divider
    localparam int DIV_STEPS = ADDR_FIELD_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // request kinds
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_ALLOCATED = 2'd0,
        ST_FREED     = 2'd1,
        ST_FULL      = 2'd2,
        ST_IGNORED   = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ALLOC_READ,
        S_ALLOC_CHECK,
        S_ALLOC_MUL,
        S_ALLOC_ADD,
        S_FREE_DIV,
        S_FREE_READ,
        S_FREE_CHECK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic                    op;
        logic [ADDR_FIELD_W-1:0] release_address;
    } t_req;

    typedef struct packed {
        logic [1:0]               status;
        logic [ADDR_FIELD_W-1:0]  granted_address;
        logic [COUNT_FIELD_W-1:0] used_count;
    } t_rsp;

    typedef struct packed {
        logic                    start;
        logic [ADDR_FIELD_W-1:0] dividend;
        logic [SIZE_W-1:0]       divisor;
    } t_div_req;

    typedef struct packed {
        logic                    done;
        logic [ADDR_FIELD_W-1:0] quotient;
    } t_div_rsp;

endpackage

`default_nettype wire

[hw/rtl/bbpa_if.sv]
// valid/ready stream interfaces for request and result beats
// depends on bbpa_pkg for the payload structs
`default_nettype none

interface bbpa_req_if;
    logic              valid;
    logic              ready;
    bbpa_pkg::t_req    payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface bbpa_rsp_if;
    logic              valid;
    logic              ready;
    bbpa_pkg::t_rsp    payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

[hw/rtl/bbpa_divider.sv]
// restoring divider, one quotient bit per cycle
// depends on bbpa_pkg for widths and the request/response structs
`default_nettype none

module bbpa_divider (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bbpa_pkg::t_div_req i_req,
    output bbpa_pkg::t_div_rsp o_rsp
);

    localparam int DW = bbpa_pkg::ADDR_FIELD_W;
    localparam int SW = bbpa_pkg::SIZE_W;
    localparam int CW = bbpa_pkg::DIV_CNT_W;

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [SW-1:0] r_rem, n_rem;
    logic [DW-1:0] r_quo, n_quo;
    logic [SW-1:0] r_den, n_den;

    logic [SW:0]   shifted;
    logic [SW+1:0] trial;

    always_comb begin
        shifted = {r_rem, r_quo[DW-1]};
        trial   = {1'b0, shifted} - {2'b00, r_den};
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_den   = r_den;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_quo  = i_req.dividend;
            n_den  = i_req.divisor;
        end else if (r_busy) begin
            // trial subtract, keep it when it does not go negative
            if (!trial[SW+1]) begin
                n_rem = trial[SW-1:0];
                n_quo = {r_quo[DW-2:0], 1'b1};
            end else begin
                n_rem = shifted[SW-1:0];
                n_quo = {r_quo[DW-2:0], 1'b0};
            end
            n_cnt = r_cnt + CW'(1);
            if (r_cnt == CW'(bbpa_pkg::DIV_STEPS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_den <= n_den;
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

`default_nettype wire

[hw/rtl/bitmap_block_pool_allocator.sv]
// fixed-size block pool allocator with a first-fit use map
// depends on bbpa_pkg, bbpa_if (request and result streams) and bbpa_divider
//
// usage
//   i_req takes one request beat: op 0 allocates the lowest free active block,
//   op 1 frees the block that release_address falls in. o_rsp gives one result
//   beat per request: status, granted address (zero unless allocated) and the
//   number of blocks in use afterwards. registers sit on an apb-style port:
//   base_address at 0x0, block_bytes at 0x4, active_blocks at 0x8; write them
//   only while no request is in flight.
// sequencing
//   one request at a time. allocate runs a row read, then a row check, for each
//   32-block row of the use map it has to scan, then a multiply and an add. free
//   waits on the bit-serial divider that turns the address offset into a block
//   index, then runs a row read and a row check.
// reset
//   i_rst_n is synchronous, active low. after it the use map is swept clear,
//   one 32-bit row per cycle, ceil(NUM_BLOCKS/32) rows in all; i_req.ready stays
//   low meanwhile, configuration writes are taken as ever.
// stalls
//   the result register holds a beat until o_rsp.ready; the next request is
//   taken meanwhile and its work runs up to its finish, where it waits.
`default_nettype none

module bitmap_block_pool_allocator #(
    parameter int NUM_BLOCKS = 64,
    parameter int ADDR_WIDTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    bbpa_req_if.sink                            i_req,
    bbpa_rsp_if.source                          o_rsp,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [bbpa_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [bbpa_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [bbpa_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    localparam int AW   = bbpa_pkg::ADDR_FIELD_W;
    localparam int SW   = bbpa_pkg::SIZE_W;
    localparam int CFW  = bbpa_pkg::COUNT_FIELD_W;
    localparam int RB   = bbpa_pkg::ROW_BITS;
    localparam int RIW  = bbpa_pkg::ROW_IDX_W;
    // use map geometry
    localparam int Rows = (NUM_BLOCKS + RB - 1) / RB;
    localparam int RowW = (Rows > 1) ? $clog2(Rows) : 1;
    localparam int IdxW = RowW + RIW;
    // block counts and limits, up to NUM_BLOCKS
    localparam int LimW = IdxW + 1;
    localparam int ProdW = IdxW + SW;
    localparam logic [LimW+CFW-1:0] CapWide = (LimW + CFW)'(NUM_BLOCKS);

    // configuration registers
    logic [AW-1:0]  r_base;
    logic [SW-1:0]  r_block;
    logic [CFW-1:0] r_active;

    // sequencer and working registers
    bbpa_pkg::t_state r_state, n_state;
    logic [RowW-1:0]  r_row, n_row;
    logic [RIW-1:0]   r_bit, n_bit;
    logic [IdxW-1:0]  r_idx, n_idx;
    logic [LimW-1:0]  r_limit, n_limit;
    logic [SW-1:0]    r_size, n_size;
    logic [LimW-1:0]  r_used, n_used;
    logic [ProdW-1:0] r_prod, n_prod;
    logic [1:0]       r_status, n_status;
    logic [AW-1:0]    r_grant, n_grant;

    // result register
    logic             r_out_valid;
    bbpa_pkg::t_rsp   r_out;
    logic             out_load;

    // use map memory, one row per entry
    logic [RB-1:0]    r_use_map [Rows];
    logic [RB-1:0]    r_rd_data;
    logic             mem_we;
    logic [RB-1:0]    mem_wdata;

    // divider
    bbpa_pkg::t_div_req div_req;
    bbpa_pkg::t_div_rsp div_rsp;

    // derived values
    logic [SW-1:0]         eff_size;
    logic [LimW+CFW-1:0]   act_wide;
    logic [LimW-1:0]       lim_cap;
    logic [LimW-1:0]       row_base;
    logic [LimW-1:0]       next_base;
    logic [LimW-1:0]       span;
    logic [RB-1:0]         row_mask;
    logic [RB-1:0]         free_vec;
    logic [RIW-1:0]        first_free;
    logic [AW+ADDR_WIDTH-1:0]    base_wide;
    logic [ProdW+ADDR_WIDTH-1:0] prod_wide;
    logic [ADDR_WIDTH-1:0]       addr_sum;
    logic [ADDR_WIDTH+AW-1:0]    grant_wide;
    logic [LimW+CFW-1:0]         used_wide;

    bbpa_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // zero block size acts as one, oversized pool is capped
    assign eff_size = (r_block == '0) ? SW'(1) : r_block;
    assign act_wide = {{LimW{1'b0}}, r_active};
    assign lim_cap  = (act_wide > CapWide) ? CapWide[LimW-1:0] : act_wide[LimW-1:0];

    // which bits of the current row lie below the active limit
    assign row_base  = {1'b0, r_row, {RIW{1'b0}}};
    assign next_base = row_base + LimW'(RB);
    assign span      = r_limit - row_base;
    assign row_mask  = (span >= LimW'(RB)) ? {RB{1'b1}}
                                           : ((RB'(1) << span[RIW-1:0]) - RB'(1));
    assign free_vec  = ~r_rd_data & row_mask;

    // lowest free bit of the row
    always_comb begin
        first_free = '0;
        for (int i = RB - 1; i >= 0; i--) begin
            if (free_vec[i]) begin
                first_free = RIW'(i);
            end
        end
    end

    // grant address wraps at ADDR_WIDTH bits
    assign base_wide  = {{ADDR_WIDTH{1'b0}}, r_base};
    assign prod_wide  = {{ADDR_WIDTH{1'b0}}, r_prod};
    assign addr_sum   = base_wide[ADDR_WIDTH-1:0] + prod_wide[ADDR_WIDTH-1:0];
    assign grant_wide = {{AW{1'b0}}, addr_sum};
    assign used_wide  = {{CFW{1'b0}}, r_used};

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_row    = r_row;
        n_bit    = r_bit;
        n_idx    = r_idx;
        n_limit  = r_limit;
        n_size   = r_size;
        n_used   = r_used;
        n_prod   = r_prod;
        n_status = r_status;
        n_grant  = r_grant;
        mem_we   = 1'b0;
        mem_wdata = '0;
        out_load = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = i_req.payload.release_address - r_base;
        div_req.divisor  = eff_size;
        i_req.ready      = (r_state == bbpa_pkg::S_IDLE);

        case (r_state)
            bbpa_pkg::S_CLEAR: begin
                mem_we = 1'b1;
                if (r_row == RowW'(Rows - 1)) begin
                    n_row   = '0;
                    n_state = bbpa_pkg::S_IDLE;
                end else begin
                    n_row = r_row + RowW'(1);
                end
            end
            bbpa_pkg::S_IDLE: begin
                if (i_req.valid) begin
                    n_limit = lim_cap;
                    n_size  = eff_size;
                    n_row   = '0;
                    n_grant = '0;
                    if (i_req.payload.op == bbpa_pkg::OP_ALLOC) begin
                        if (lim_cap == '0) begin
                            n_status = bbpa_pkg::ST_FULL;
                            n_state  = bbpa_pkg::S_DONE;
                        end else begin
                            n_state = bbpa_pkg::S_ALLOC_READ;
                        end
                    end else if (i_req.payload.release_address >= r_base) begin
                        div_req.start = 1'b1;
                        n_state = bbpa_pkg::S_FREE_DIV;
                    end else begin
                        n_status = bbpa_pkg::ST_IGNORED;
                        n_state  = bbpa_pkg::S_DONE;
                    end
                end
            end
            bbpa_pkg::S_ALLOC_READ: begin
                n_state = bbpa_pkg::S_ALLOC_CHECK;
            end
            bbpa_pkg::S_ALLOC_CHECK: begin
                if (free_vec != '0) begin
                    mem_we    = 1'b1;
                    mem_wdata = r_rd_data | (RB'(1) << first_free);
                    n_idx     = {r_row, first_free};
                    n_used    = r_used + LimW'(1);
                    n_state   = bbpa_pkg::S_ALLOC_MUL;
                end else if (next_base < r_limit) begin
                    n_row   = r_row + RowW'(1);
                    n_state = bbpa_pkg::S_ALLOC_READ;
                end else begin
                    n_status = bbpa_pkg::ST_FULL;
                    n_state  = bbpa_pkg::S_DONE;
                end
            end
            bbpa_pkg::S_ALLOC_MUL: begin
                n_prod  = ProdW'(r_idx) * ProdW'(r_size);
                n_state = bbpa_pkg::S_ALLOC_ADD;
            end
            bbpa_pkg::S_ALLOC_ADD: begin
                n_grant  = grant_wide[AW-1:0];
                n_status = bbpa_pkg::ST_ALLOCATED;
                n_state  = bbpa_pkg::S_DONE;
            end
            bbpa_pkg::S_FREE_DIV: begin
                if (div_rsp.done) begin
                    if (div_rsp.quotient < AW'(r_limit)) begin
                        n_row   = div_rsp.quotient[IdxW-1:RIW];
                        n_bit   = div_rsp.quotient[RIW-1:0];
                        n_state = bbpa_pkg::S_FREE_READ;
                    end else begin
                        n_status = bbpa_pkg::ST_IGNORED;
                        n_state  = bbpa_pkg::S_DONE;
                    end
                end
            end
            bbpa_pkg::S_FREE_READ: begin
                n_state = bbpa_pkg::S_FREE_CHECK;
            end
            bbpa_pkg::S_FREE_CHECK: begin
                if (r_rd_data[r_bit]) begin
                    mem_we    = 1'b1;
                    mem_wdata = r_rd_data & ~(RB'(1) << r_bit);
                    n_used    = r_used - LimW'(1);
                    n_status  = bbpa_pkg::ST_FREED;
                end else begin
                    n_status = bbpa_pkg::ST_IGNORED;
                end
                n_state = bbpa_pkg::S_DONE;
            end
            bbpa_pkg::S_DONE: begin
                // wait here while the result register still holds an untaken beat
                if (!r_out_valid || o_rsp.ready) begin
                    out_load = 1'b1;
                    n_state  = bbpa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bbpa_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bbpa_pkg::S_CLEAR;
            r_row   <= '0;
            r_used  <= '0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_used  <= n_used;
        end
        r_bit    <= n_bit;
        r_idx    <= n_idx;
        r_limit  <= n_limit;
        r_size   <= n_size;
        r_prod   <= n_prod;
        r_status <= n_status;
        r_grant  <= n_grant;
    end

    // use map row memory, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_use_map[r_row] <= mem_wdata;
        end
        r_rd_data <= r_use_map[r_row];
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
        if (out_load) begin
            r_out.status          <= r_status;
            r_out.granted_address <= r_grant;
            r_out.used_count      <= used_wide[CFW-1:0];
        end
    end

    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_out;

    // configuration port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base   <= bbpa_pkg::RST_BASE_ADDRESS;
            r_block  <= bbpa_pkg::RST_BLOCK_BYTES;
            r_active <= bbpa_pkg::RST_ACTIVE_BLOCKS;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[bbpa_pkg::APB_ADDR_W-1:2])
                bbpa_pkg::REG_BASE_ADDRESS:  r_base   <= pwdata[AW-1:0];
                bbpa_pkg::REG_BLOCK_BYTES:   r_block  <= pwdata[SW-1:0];
                bbpa_pkg::REG_ACTIVE_BLOCKS: r_active <= pwdata[CFW-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[bbpa_pkg::APB_ADDR_W-1:2])
            bbpa_pkg::REG_BASE_ADDRESS:  prdata = r_base;
            bbpa_pkg::REG_BLOCK_BYTES:   prdata = {{(bbpa_pkg::APB_DATA_W - SW){1'b0}}, r_block};
            bbpa_pkg::REG_ACTIVE_BLOCKS: prdata = {{(bbpa_pkg::APB_DATA_W - CFW){1'b0}}, r_active};
            default:                     prdata = '0;
        endcase
    end

    assign pready = 1'b1;

endmodule

`default_nettype wire

[hw/rtl/bbpa_checker.sv]
// port-level assertions for the bitmap block pool allocator, bound to the top level
// depends on bbpa_pkg for status codes
`default_nettype none

module bbpa_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_req_valid,
    input logic        i_req_ready,
    input logic        i_rsp_valid,
    input logic        i_rsp_ready,
    input logic [1:0]  i_rsp_status,
    input logic [31:0] i_rsp_granted,
    input logic [6:0]  i_rsp_used
);

    // reset leaves no request taken and no result beat shown
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_req_ready && !i_rsp_valid)
        else $error("request ready or result valid right after reset");

    // one request at a time: busy right after a request beat
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request taken while one is in flight");

    // only a grant carries an address
    a_grant_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_status != bbpa_pkg::ST_ALLOCATED |-> i_rsp_granted == '0)
        else $error("address given without a grant");

    // a stalled result beat holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_status)
            && $stable(i_rsp_granted) && $stable(i_rsp_used))
        else $error("result beat changed while stalled");

endmodule

bind bitmap_block_pool_allocator bbpa_checker u_bbpa_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_req_valid   (i_req.valid),
    .i_req_ready   (i_req.ready),
    .i_rsp_valid   (o_rsp.valid),
    .i_rsp_ready   (o_rsp.ready),
    .i_rsp_status  (o_rsp.payload.status),
    .i_rsp_granted (o_rsp.payload.granted_address),
    .i_rsp_used    (o_rsp.payload.used_count)
);

`default_nettype wire
